// ===== hw/rtl/fbc_pkg.sv =====
`default_nettype none
// ============================================================================
// fbc_pkg
// Shared types and constants of the frustum box cull unit: coefficient and
// plane widths, command and visibility codes, result queue depth.
// ============================================================================
package fbc_pkg;

    // Matrix coefficients: signed Q16.16
    localparam int COEF_W      = 32;
    localparam int COEF_COUNT  = 16;
    localparam int COEF_IDX_W  = 4;
    localparam int ROW_LEN     = 4;
    // First coefficient of row 3 (w row)
    localparam int ROW3_BASE   = 12;

    // Plane coefficients: exact sum or difference of two coefficients
    localparam int PLANE_W     = COEF_W + 1;
    localparam int PLANE_COUNT = 5;
    localparam int FRAC_BITS   = 16;
    localparam int AXIS_COUNT  = 3;
    localparam int CORNER_COUNT = 8;

    // Default coordinate width, signed Q(COORD_WIDTH-16).16
    localparam int COORD_WIDTH_DEF = 32;

    // Result queue depth, power of two, above the pipeline latency
    localparam int OUT_DEPTH   = 8;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TEST = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        VIS_INVISIBLE = 2'd0,
        VIS_PARTIAL   = 2'd1,
        VIS_FULL      = 2'd2
    } t_vis;

    typedef struct packed {
        logic signed [PLANE_W-1:0] a;
        logic signed [PLANE_W-1:0] b;
        logic signed [PLANE_W-1:0] c;
        logic signed [PLANE_W-1:0] d;
    } t_plane;

    // Row 3 plus or minus another row's coefficient, exact
    function automatic logic signed [PLANE_W-1:0] plane_coef(
        input logic signed [COEF_W-1:0] r3,
        input logic signed [COEF_W-1:0] rr,
        input logic                     minus
    );
        logic signed [PLANE_W-1:0] a3;
        logic signed [PLANE_W-1:0] ar;
        a3 = PLANE_W'(r3);
        ar = PLANE_W'(rr);
        return minus ? (a3 - ar) : (a3 + ar);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/frustum_box_cull_unit.sv =====
`default_nettype none
// ============================================================================
// frustum_box_cull_unit
// View-frustum culling of axis-aligned boxes and points against the left,
// right, bottom, top and near planes of a loaded view-projection matrix.
// ============================================================================
// One request enters per cycle. A load request (command 0) writes one matrix
// coefficient and returns nothing; it applies to every test request accepted
// after it. A test request (command 1) returns one visibility code: the five
// planes are formed from the matrix and registered with the box bounds, pass
// through the per-plane multiply/add pipeline, and their corner signs are
// reduced into the result queue. Throughput is one request per cycle as
// long as results are drained; input ready drops only while eight test
// results are outstanding (in flight plus queued), the depth of the result
// queue. The matrix resets to all zero.
// ============================================================================
module frustum_box_cull_unit #(
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_command,
    input  wire logic [fbc_pkg::COEF_IDX_W-1:0]    i_coef_index,
    input  wire logic signed [fbc_pkg::COEF_W-1:0] i_coef_value,
    input  wire logic signed [COORD_WIDTH-1:0]     i_x_min,
    input  wire logic signed [COORD_WIDTH-1:0]     i_x_max,
    input  wire logic signed [COORD_WIDTH-1:0]     i_y_min,
    input  wire logic signed [COORD_WIDTH-1:0]     i_y_max,
    input  wire logic signed [COORD_WIDTH-1:0]     i_z_min,
    input  wire logic signed [COORD_WIDTH-1:0]     i_z_max,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_visibility
);

    localparam int PEND_W = $clog2(fbc_pkg::OUT_DEPTH + 1);
    localparam int NSTAGE = 5;

    logic signed [fbc_pkg::COEF_W-1:0] r_store [fbc_pkg::COEF_COUNT];

    logic                          in_acc;
    logic                          load_acc;
    logic                          test_acc;
    logic                          out_acc;

    fbc_pkg::t_plane               n_plane [fbc_pkg::PLANE_COUNT];
    fbc_pkg::t_plane               r_plane [fbc_pkg::PLANE_COUNT];
    logic signed [COORD_WIDTH-1:0] r_cmin  [fbc_pkg::AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] r_cmax  [fbc_pkg::AXIS_COUNT];
    logic [NSTAGE-1:0]             r_valid;
    logic [PEND_W-1:0]             r_pending;

    logic [fbc_pkg::CORNER_COUNT-1:0] plane_pos [fbc_pkg::PLANE_COUNT];
    logic                          any_out;
    logic                          all_in;
    fbc_pkg::t_vis                 vis;
    fbc_pkg::t_vis                 fifo_data;

    assign in_acc   = i_in_valid && o_in_ready;
    assign load_acc = in_acc && (i_command == fbc_pkg::CMD_LOAD);
    assign test_acc = in_acc && (i_command == fbc_pkg::CMD_TEST);
    assign out_acc  = o_out_valid && i_out_ready;

    // Hold requests while the result queue could not take every outstanding test
    assign o_in_ready = (r_pending < PEND_W'(fbc_pkg::OUT_DEPTH));

    // Write the matrix on load requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fbc_pkg::COEF_COUNT; i++) begin
                r_store[i] <= '0;
            end
        end else if (load_acc) begin
            r_store[i_coef_index] <= i_coef_value;
        end
    end

    // Form the five planes: row 3 plus or minus rows 0..2 (far plane skipped)
    for (genvar p = 0; p < fbc_pkg::PLANE_COUNT; p++) begin : g_plane_form
        localparam int   RB    = (p / 2) * fbc_pkg::ROW_LEN;
        localparam logic MINUS = (p % 2) != 0;
        assign n_plane[p].a = fbc_pkg::plane_coef(r_store[fbc_pkg::ROW3_BASE + 0],
                                                  r_store[RB + 0], MINUS);
        assign n_plane[p].b = fbc_pkg::plane_coef(r_store[fbc_pkg::ROW3_BASE + 1],
                                                  r_store[RB + 1], MINUS);
        assign n_plane[p].c = fbc_pkg::plane_coef(r_store[fbc_pkg::ROW3_BASE + 2],
                                                  r_store[RB + 2], MINUS);
        assign n_plane[p].d = fbc_pkg::plane_coef(r_store[fbc_pkg::ROW3_BASE + 3],
                                                  r_store[RB + 3], MINUS);
    end

    // Stage 1: capture planes and box bounds
    always_ff @(posedge i_clk) begin
        r_plane   <= n_plane;
        r_cmin[0] <= i_x_min;
        r_cmax[0] <= i_x_max;
        r_cmin[1] <= i_y_min;
        r_cmax[1] <= i_y_max;
        r_cmin[2] <= i_z_min;
        r_cmax[2] <= i_z_max;
    end

    // Advance test valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[NSTAGE-2:0], test_acc};
        end
    end

    // Count tests accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({test_acc, out_acc})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    // Per-plane corner evaluation
    for (genvar p = 0; p < fbc_pkg::PLANE_COUNT; p++) begin : g_plane_eval
        fbc_plane_eval #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_plane_eval (
            .i_clk   (i_clk),
            .i_plane (r_plane[p]),
            .i_cmin  (r_cmin),
            .i_cmax  (r_cmax),
            .o_pos   (plane_pos[p])
        );
    end

    // Reduce corner signs: any plane with no positive corner culls the box
    always_comb begin
        any_out = 1'b0;
        all_in  = 1'b1;
        for (int p = 0; p < fbc_pkg::PLANE_COUNT; p++) begin
            if (plane_pos[p] == '0) begin
                any_out = 1'b1;
            end
            if (plane_pos[p] != '1) begin
                all_in = 1'b0;
            end
        end
        if (any_out) begin
            vis = fbc_pkg::VIS_INVISIBLE;
        end else if (all_in) begin
            vis = fbc_pkg::VIS_FULL;
        end else begin
            vis = fbc_pkg::VIS_PARTIAL;
        end
    end

    fbc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_valid[NSTAGE-1]),
        .i_data  (vis),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (fifo_data)
    );

    assign o_visibility = fifo_data;

`ifndef NO_ASSERTIONS
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(fbc_pkg::OUT_DEPTH))
        else $error("outstanding test count exceeds result queue depth");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != '0))
        else $error("result offered with no outstanding test");

    a_load_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_acc |=> (r_store[$past(i_coef_index)] == $past(i_coef_value)))
        else $error("load request did not update the matrix");

    a_test_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_valid[0] == $past(i_command == fbc_pkg::CMD_TEST)))
        else $error("stage 1 valid does not match accepted request kind");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/fbc_plane_eval.sv =====
`default_nettype none
// ============================================================================
// fbc_plane_eval
// Four-stage evaluation of one plane at the eight box corners: split
// partial products, full products, pair sums, corner sums and sign flags.
// ============================================================================
module fbc_plane_eval #(
    parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire fbc_pkg::t_plane               i_plane,
    input  wire logic signed [COORD_WIDTH-1:0] i_cmin [fbc_pkg::AXIS_COUNT],
    input  wire logic signed [COORD_WIDTH-1:0] i_cmax [fbc_pkg::AXIS_COUNT],
    output logic [fbc_pkg::CORNER_COUNT-1:0]   o_pos
);

    localparam int PW    = fbc_pkg::PLANE_W;
    localparam int LO_W  = COORD_WIDTH / 2;
    localparam int HI_W  = COORD_WIDTH - LO_W;
    localparam int PPL_W = PW + LO_W + 1;
    localparam int PPH_W = PW + HI_W;
    localparam int P     = PW + COORD_WIDTH;
    localparam int S     = P + 2;

    logic signed [PW-1:0]          axis_coef [fbc_pkg::AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] coord     [fbc_pkg::AXIS_COUNT][2];

    logic signed [PPL_W-1:0] n_pp_lo [fbc_pkg::AXIS_COUNT][2];
    logic signed [PPH_W-1:0] n_pp_hi [fbc_pkg::AXIS_COUNT][2];
    logic signed [PPL_W-1:0] r_pp_lo [fbc_pkg::AXIS_COUNT][2];
    logic signed [PPH_W-1:0] r_pp_hi [fbc_pkg::AXIS_COUNT][2];
    logic signed [PW-1:0]    r_d_a;

    logic signed [P-1:0]     n_prod  [fbc_pkg::AXIS_COUNT][2];
    logic signed [P-1:0]     r_prod  [fbc_pkg::AXIS_COUNT][2];
    logic signed [PW-1:0]    r_d_b;

    logic signed [S-1:0]     dsc;
    logic signed [S-1:0]     n_dx [2];
    logic signed [S-1:0]     n_yz [4];
    logic signed [S-1:0]     r_dx [2];
    logic signed [S-1:0]     r_yz [4];

    logic signed [S-1:0]                corner_sum [fbc_pkg::CORNER_COUNT];
    logic [fbc_pkg::CORNER_COUNT-1:0]   n_pos;
    logic [fbc_pkg::CORNER_COUNT-1:0]   r_pos;

    // Gather plane coefficient per axis and min/max coordinates
    always_comb begin
        axis_coef[0] = i_plane.a;
        axis_coef[1] = i_plane.b;
        axis_coef[2] = i_plane.c;
        for (int k = 0; k < fbc_pkg::AXIS_COUNT; k++) begin
            coord[k][0] = i_cmin[k];
            coord[k][1] = i_cmax[k];
        end
    end

    // Stage A: split each coordinate into an unsigned low half and signed high half
    always_comb begin
        for (int k = 0; k < fbc_pkg::AXIS_COUNT; k++) begin
            for (int m = 0; m < 2; m++) begin
                n_pp_lo[k][m] = PPL_W'(axis_coef[k])
                              * PPL_W'($signed({1'b0, coord[k][m][LO_W-1:0]}));
                n_pp_hi[k][m] = PPH_W'(axis_coef[k])
                              * PPH_W'($signed(coord[k][m][COORD_WIDTH-1:LO_W]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp_lo <= n_pp_lo;
        r_pp_hi <= n_pp_hi;
        r_d_a   <= i_plane.d;
    end

    // Stage B: recombine partial products into exact full products
    always_comb begin
        for (int k = 0; k < fbc_pkg::AXIS_COUNT; k++) begin
            for (int m = 0; m < 2; m++) begin
                n_prod[k][m] = (P'(r_pp_hi[k][m]) <<< LO_W) + P'(r_pp_lo[k][m]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_d_b  <= r_d_a;
    end

    // Stage C: offset plus x term, and the four y plus z combinations
    always_comb begin
        dsc = S'(r_d_b) <<< fbc_pkg::FRAC_BITS;
        for (int m = 0; m < 2; m++) begin
            n_dx[m] = dsc + S'(r_prod[0][m]);
        end
        for (int j = 0; j < 4; j++) begin
            n_yz[j] = S'(r_prod[1][j % 2]) + S'(r_prod[2][j / 2]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= n_dx;
        r_yz <= n_yz;
    end

    // Stage D: corner sums, flag strictly positive ones
    always_comb begin
        for (int c = 0; c < fbc_pkg::CORNER_COUNT; c++) begin
            corner_sum[c] = r_dx[c % 2] + r_yz[c / 2];
            n_pos[c]      = !corner_sum[c][S-1] && (corner_sum[c] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

    assign o_pos = r_pos;

endmodule
`default_nettype wire

// ===== hw/rtl/fbc_out_fifo.sv =====
`default_nettype none
// ============================================================================
// fbc_out_fifo
// Result queue between the evaluation pipeline and the output channel.
// Upstream credit accounting guarantees a push never meets a full queue.
// ============================================================================
module fbc_out_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire fbc_pkg::t_vis i_data,
    input  wire logic          i_pop,
    output logic               o_valid,
    output fbc_pkg::t_vis      o_data
);

    localparam int PTR_W = $clog2(fbc_pkg::OUT_DEPTH);
    localparam int CNT_W = $clog2(fbc_pkg::OUT_DEPTH + 1);

    fbc_pkg::t_vis    r_mem [fbc_pkg::OUT_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(fbc_pkg::OUT_DEPTH - 1)) ? '0
                                                                        : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(fbc_pkg::OUT_DEPTH - 1)) ? '0
                                                                        : r_rd_ptr + 1'b1;
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule
`default_nettype wire
